### src/dmarhc_pkg.sv
// ----------------------------------------------------------------------------
// dmarhc_pkg
// Shared sizes, outcome codes, history entry type and helper functions for the
// DMA reorder hazard check.
// ----------------------------------------------------------------------------
package dmarhc_pkg;

  localparam int QUEUE_COUNT   = 16;
  localparam int HISTORY_DEPTH = 2;
  localparam int TILE_COUNT    = 6;
  localparam int OFFSET_BITS   = 32;

  // fixed descriptor field widths
  localparam int QUEUE_NUM_W = 4;
  localparam int MEM_W       = 2;
  localparam int TILE_W      = 6;
  localparam int OFFSET_W    = 32;
  localparam int LENGTH_W    = 33;
  localparam int OUTCOME_W   = 2;
  // offset plus length can carry one bit past the length width
  localparam int END_W       = LENGTH_W + 1;

  localparam int QUEUE_W     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int CNT_W       = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int ENTRY_COUNT = QUEUE_COUNT * HISTORY_DEPTH;
  localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam logic [TILE_W-1:0] TILE_MASK =
    (TILE_COUNT >= TILE_W) ? {TILE_W{1'b1}} : TILE_W'((1 << TILE_COUNT) - 1);
  localparam logic [OFFSET_W-1:0] OFFSET_MASK =
    (OFFSET_BITS >= OFFSET_W) ? {OFFSET_W{1'b1}}
                              : OFFSET_W'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [LENGTH_W-1:0] LENGTH_MASK =
    (OFFSET_BITS + 1 >= LENGTH_W) ? {LENGTH_W{1'b1}}
                                  : LENGTH_W'((64'd1 << (OFFSET_BITS + 1)) - 64'd1);

  localparam logic [OUTCOME_W-1:0] OUTCOME_FIRST     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_OVERLAP   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_REORDERED = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_PROFILING = 2'd3;

  typedef struct packed {
    logic [MEM_W-1:0]    mem;
    logic [TILE_W-1:0]   tiles;
    logic [OFFSET_W-1:0] start;
    logic [END_W-1:0]    stop;
  } entry_t;

  // queue number folded onto the implemented queues, as a small table
  function automatic logic [QUEUE_W-1:0] queue_wrap(input logic [QUEUE_NUM_W-1:0] x);
    logic [QUEUE_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << QUEUE_NUM_W); i++) begin
      if (x == QUEUE_NUM_W'(i)) r = QUEUE_W'(i % QUEUE_COUNT);
    end
    return r;
  endfunction

  // ring position of the i-th oldest entry
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                input logic [CNT_W-1:0]  i);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(i);
    if (s >= (CNT_W + 1)'(HISTORY_DEPTH)) s = s - (CNT_W + 1)'(HISTORY_DEPTH);
    return SLOT_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [QUEUE_W-1:0] q,
                                                   input logic [SLOT_W-1:0]  slot);
    return ADDR_W'(q) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot);
  endfunction

  function automatic logic buffers_overlap(input entry_t a, input entry_t b);
    logic tile_ok;
    logic range_ok;
    tile_ok  = (a.tiles == '0) || (b.tiles == '0) || ((a.tiles & b.tiles) != '0);
    range_ok = (a.stop > END_W'(b.start)) && (b.stop > END_W'(a.start));
    return (a.mem == b.mem) && tile_ok && range_ok;
  endfunction

endpackage

### src/dmarhc_if.sv
// ----------------------------------------------------------------------------
// dmarhc channel interfaces
// Valid/ready channels for descriptor beats in and decision beats out.
// ----------------------------------------------------------------------------
interface dmarhc_in_if import dmarhc_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [QUEUE_NUM_W-1:0] queue_number;
  logic                   profiling_dma;
  logic                   source_is_constant;
  logic [MEM_W-1:0]       source_memory;
  logic [TILE_W-1:0]      source_tiles;
  logic [OFFSET_W-1:0]    source_offset;
  logic [LENGTH_W-1:0]    source_length;
  logic [MEM_W-1:0]       dest_memory;
  logic [TILE_W-1:0]      dest_tiles;
  logic [OFFSET_W-1:0]    dest_offset;
  logic [LENGTH_W-1:0]    dest_length;

  modport source (
    output valid, queue_number, profiling_dma, source_is_constant, source_memory,
           source_tiles, source_offset, source_length, dest_memory, dest_tiles,
           dest_offset, dest_length,
    input  ready
  );
  modport sink (
    input  valid, queue_number, profiling_dma, source_is_constant, source_memory,
           source_tiles, source_offset, source_length, dest_memory, dest_tiles,
           dest_offset, dest_length,
    output ready
  );
endinterface

interface dmarhc_out_if import dmarhc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic                 out_of_order;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, out_of_order, outcome, input ready);
  modport sink   (input valid, out_of_order, outcome, output ready);
endinterface

### src/dmarhc_ram.sv
// ----------------------------------------------------------------------------
// dmarhc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dmarhc_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### src/dma_reorder_hazard_check_core.sv
// ----------------------------------------------------------------------------
// dma_reorder_hazard_check_core
// Per-queue destination history and source overlap check for DMA reordering.
// ----------------------------------------------------------------------------
// flow: profiling, first-on-queue and constant-source descriptors go from S_DECIDE
//   straight to S_RESULT; others walk the queue history in S_COMP, reading up to
//   HISTORY_DEPTH entries one per cycle from the history RAM until a hit or the last one
// one descriptor in work at a time: a new one is taken only back in S_IDLE
// reset: synchronous rst empties every queue history at once, no clearing pass
module dma_reorder_hazard_check_core import dmarhc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dmarhc_in_if.sink     req,
  dmarhc_out_if.source  rsp
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_COMP   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state;

  // captured descriptor
  logic [QUEUE_W-1:0] q;
  logic               prof;
  logic               src_const;
  entry_t             src;
  entry_t             dst;
  logic [CNT_W-1:0]   idx;
  logic [OUTCOME_W-1:0] res_outcome;

  // per-queue ring control
  logic [CNT_W-1:0]  hist_count [QUEUE_COUNT];
  logic [SLOT_W-1:0] hist_base  [QUEUE_COUNT];

  logic                 out_valid;
  logic                 out_ooo;
  logic [OUTCOME_W-1:0] out_outcome;

  entry_t             rd_entry;
  logic               hit;
  logic               last;
  logic [CNT_W-1:0]   cur_cnt;
  logic [SLOT_W-1:0]  cur_base;
  logic               push_en;
  logic [CNT_W-1:0]   push_cnt;
  logic [SLOT_W-1:0]  wr_slot;
  logic [CNT_W-1:0]   cnt_next;
  logic [SLOT_W-1:0]  base_next;
  logic               rd_en;
  logic [CNT_W-1:0]   rd_idx;
  logic               out_free;

  assign cur_cnt  = hist_count[q];
  assign cur_base = hist_base[q];
  assign hit      = buffers_overlap(rd_entry, src);
  assign last     = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(cur_cnt);
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    push_en  = 1'b0;
    push_cnt = cur_cnt;
    rd_en    = 1'b0;
    rd_idx   = idx;
    case (state)
      S_DECIDE: begin
        if (!prof) begin
          if (cur_cnt == '0 || src_const) begin
            push_en = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rd_idx = '0;
          end
        end
      end
      S_COMP: begin
        if (hit) begin
          // history emptied before the new destination goes in
          push_en  = 1'b1;
          push_cnt = '0;
        end else if (last) begin
          push_en = 1'b1;
        end else begin
          rd_en  = 1'b1;
          rd_idx = idx + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (push_cnt < CNT_W'(HISTORY_DEPTH)) begin
      wr_slot   = slot_of(cur_base, push_cnt);
      cnt_next  = push_cnt + CNT_W'(1);
      base_next = cur_base;
    end else begin
      // full: overwrite the oldest and move the ring on
      wr_slot   = cur_base;
      cnt_next  = push_cnt;
      base_next = slot_of(cur_base, CNT_W'(1));
    end
  end

  dmarhc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (entry_addr(q, wr_slot)),
    .wr_data (dst),
    .rd_en   (rd_en),
    .rd_addr (entry_addr(q, slot_of(cur_base, rd_idx))),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        hist_count[i] <= '0;
        hist_base[i]  <= '0;
      end
    end else begin
      if (out_valid && rsp.ready && state != S_RESULT) out_valid <= 1'b0;
      if (push_en) begin
        hist_count[q] <= cnt_next;
        hist_base[q]  <= base_next;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (prof) begin
            hist_count[q] <= '0;
            res_outcome   <= OUTCOME_PROFILING;
            state         <= S_RESULT;
          end else if (cur_cnt == '0) begin
            res_outcome <= OUTCOME_FIRST;
            state       <= S_RESULT;
          end else if (src_const) begin
            res_outcome <= OUTCOME_REORDERED;
            state       <= S_RESULT;
          end else begin
            idx   <= '0;
            state <= S_COMP;
          end
        end
        S_COMP: begin
          if (hit) begin
            res_outcome <= OUTCOME_OVERLAP;
            state       <= S_RESULT;
          end else if (last) begin
            res_outcome <= OUTCOME_REORDERED;
            state       <= S_RESULT;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_outcome <= res_outcome;
            out_ooo     <= (res_outcome == OUTCOME_REORDERED);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // descriptor capture on the accepted beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      q         <= queue_wrap(req.queue_number);
      prof      <= req.profiling_dma;
      src_const <= req.source_is_constant;
      src.mem   <= req.source_memory;
      src.tiles <= req.source_tiles & TILE_MASK;
      src.start <= req.source_offset & OFFSET_MASK;
      src.stop  <= END_W'(req.source_offset & OFFSET_MASK)
                 + END_W'(req.source_length & LENGTH_MASK);
      dst.mem   <= req.dest_memory;
      dst.tiles <= req.dest_tiles & TILE_MASK;
      dst.start <= req.dest_offset & OFFSET_MASK;
      dst.stop  <= END_W'(req.dest_offset & OFFSET_MASK)
                 + END_W'(req.dest_length & LENGTH_MASK);
    end
  end

  assign req.ready        = (state == S_IDLE) && !rst;
  assign rsp.valid        = out_valid;
  assign rsp.out_of_order = out_ooo;
  assign rsp.outcome      = out_outcome;

endmodule

### src/dmarhc_checker.sv
// ----------------------------------------------------------------------------
// dmarhc_checker
// Port-level assertions for the DMA reorder hazard check, bound to the core.
// ----------------------------------------------------------------------------
module dmarhc_checker import dmarhc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic                 rsp_out_of_order,
  input logic [OUTCOME_W-1:0] rsp_outcome
);

  // one descriptor in flight: no back-to-back acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("descriptor accepted while previous one still in work");

  // the ordering flag is set for reordered decisions only
  a_flag_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_out_of_order == (rsp_outcome == OUTCOME_REORDERED)))
    else $error("out_of_order disagrees with outcome");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
                               && $stable(rsp_out_of_order))
    else $error("stalled decision beat changed or dropped");

endmodule

bind dma_reorder_hazard_check_core dmarhc_checker u_dmarhc_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_out_of_order (rsp.out_of_order),
  .rsp_outcome      (rsp.outcome)
);

### tb/tb_dma_reorder_hazard_check_core.sv
// ----------------------------------------------------------------------------
// tb_dma_reorder_hazard_check_core
// Drives DMA descriptor beats into the hazard check and compares every
// decision beat against a per-queue destination history kept in the bench.
// Covers directed overlap corner cases, a long stall on the decision side
// and a long run of random descriptor traffic with random idling.
// ----------------------------------------------------------------------------
module tb_dma_reorder_hazard_check_core;
  import dmarhc_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [QUEUE_NUM_W-1:0] queue_number;
    logic                   profiling_dma;
    logic                   source_is_constant;
    logic [MEM_W-1:0]       source_memory;
    logic [TILE_W-1:0]      source_tiles;
    logic [OFFSET_W-1:0]    source_offset;
    logic [LENGTH_W-1:0]    source_length;
    logic [MEM_W-1:0]       dest_memory;
    logic [TILE_W-1:0]      dest_tiles;
    logic [OFFSET_W-1:0]    dest_offset;
    logic [LENGTH_W-1:0]    dest_length;
  } desc_t;

  typedef struct packed {
    logic                 out_of_order;
    logic [OUTCOME_W-1:0] outcome;
  } decision_t;

  logic clk;
  logic rst;

  dmarhc_in_if  desc_bus ();
  dmarhc_out_if decision_bus ();

  dma_reorder_hazard_check_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (desc_bus),
    .rsp (decision_bus)
  );

  // destination history per queue, oldest entry first
  int unsigned hist_count [QUEUE_COUNT];
  entry_t      hist_span  [QUEUE_COUNT][HISTORY_DEPTH];

  decision_t   pending_decisions [$];
  int unsigned fail_count;
  bit          req_idling;
  bit          rsp_idling;
  int unsigned hold_asked;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic entry_t make_span(input logic [MEM_W-1:0] mem,
                                       input logic [TILE_W-1:0] tiles,
                                       input logic [OFFSET_W-1:0] offset,
                                       input logic [LENGTH_W-1:0] length);
    entry_t s;
    s.mem   = mem;
    s.tiles = tiles & TILE_MASK;
    s.start = offset & OFFSET_MASK;
    s.stop  = END_W'(s.start) + END_W'(length & LENGTH_MASK);
    return s;
  endfunction

  function automatic bit spans_collide(input entry_t a, input entry_t b);
    if (a.mem != b.mem) return 1'b0;
    if (a.tiles != '0 && b.tiles != '0 && (a.tiles & b.tiles) == '0) return 1'b0;
    // half-open ranges, ends never wrap
    return (a.stop > END_W'(b.start)) && (b.stop > END_W'(a.start));
  endfunction

  function automatic void push_span(input int unsigned q, input entry_t s);
    if (hist_count[q] >= HISTORY_DEPTH) begin
      for (int i = 1; i < HISTORY_DEPTH; i++) hist_span[q][i-1] = hist_span[q][i];
      hist_count[q] = HISTORY_DEPTH - 1;
    end
    hist_span[q][hist_count[q]] = s;
    hist_count[q]++;
  endfunction

  function automatic void predict_ordering(input desc_t d);
    int unsigned q;
    entry_t      src_span;
    entry_t      dst_span;
    decision_t   dec;
    bit          hit;
    q        = d.queue_number % QUEUE_COUNT;
    src_span = make_span(d.source_memory, d.source_tiles, d.source_offset,
                         d.source_length);
    dst_span = make_span(d.dest_memory, d.dest_tiles, d.dest_offset, d.dest_length);
    hit      = 1'b0;
    dec.out_of_order = 1'b0;
    if (d.profiling_dma) begin
      hist_count[q] = 0;
      dec.outcome   = OUTCOME_PROFILING;
    end else if (hist_count[q] == 0) begin
      push_span(q, dst_span);
      dec.outcome = OUTCOME_FIRST;
    end else begin
      if (!d.source_is_constant) begin
        for (int i = 0; i < hist_count[q]; i++) begin
          if (spans_collide(hist_span[q][i], src_span)) hit = 1'b1;
        end
      end
      if (hit) begin
        hist_count[q] = 0;
        dec.outcome   = OUTCOME_OVERLAP;
      end else begin
        dec.out_of_order = 1'b1;
        dec.outcome      = OUTCOME_REORDERED;
      end
      push_span(q, dst_span);
    end
    pending_decisions.insert(pending_decisions.size(), dec);
  endfunction

  function automatic desc_t descriptor(
    input int unsigned q, input bit prof, input bit cst,
    input int unsigned smem, input int unsigned stile,
    input logic [OFFSET_W-1:0] soff, input logic [LENGTH_W-1:0] slen,
    input int unsigned dmem, input int unsigned dtile,
    input logic [OFFSET_W-1:0] doff, input logic [LENGTH_W-1:0] dlen);
    desc_t d;
    d.queue_number       = QUEUE_NUM_W'(q);
    d.profiling_dma      = prof;
    d.source_is_constant = cst;
    d.source_memory      = MEM_W'(smem);
    d.source_tiles       = TILE_W'(stile);
    d.source_offset      = soff;
    d.source_length      = slen;
    d.dest_memory        = MEM_W'(dmem);
    d.dest_tiles         = TILE_W'(dtile);
    d.dest_offset        = doff;
    d.dest_length        = dlen;
    return d;
  endfunction

  function automatic logic [TILE_W-1:0] pick_tiles();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 8) return TILE_W'(1) << $urandom_range(0, TILE_W - 1);
    return TILE_W'($urandom);
  endfunction

  // most traffic lands in a small window so overlaps are common
  function automatic logic [OFFSET_W-1:0] window_offset();
    if ($urandom_range(0, 9) == 0) return 32'hFFFF_FE00 + $urandom_range(0, 511);
    return $urandom_range(0, 511);
  endfunction

  function automatic logic [LENGTH_W-1:0] window_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return 33'h1_0000_0000;
    return LENGTH_W'($urandom_range(1, 128));
  endfunction

  function automatic logic [LENGTH_W-1:0] wide_length();
    if ($urandom_range(0, 9) == 0) return 33'h1_0000_0000;
    return {1'b0, 32'($urandom)};
  endfunction

  function automatic desc_t random_descriptor();
    desc_t       d;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    d.queue_number = ($urandom_range(0, 4) == 0) ? QUEUE_NUM_W'($urandom)
                                                 : QUEUE_NUM_W'($urandom_range(0, 3));
    d.profiling_dma      = (kind < 5);
    d.source_is_constant = (kind >= 5 && kind < 10) || ($urandom_range(0, 49) == 0);
    if (kind >= 90) begin
      // noise: anything the fields allow
      d.source_memory = MEM_W'($urandom);
      d.source_tiles  = TILE_W'($urandom);
      d.source_offset = 32'($urandom);
      d.source_length = wide_length();
      d.dest_memory   = MEM_W'($urandom);
      d.dest_tiles    = TILE_W'($urandom);
      d.dest_offset   = 32'($urandom);
      d.dest_length   = wide_length();
    end else begin
      d.source_memory = MEM_W'($urandom_range(0, 1));
      d.source_tiles  = pick_tiles();
      d.source_offset = window_offset();
      d.source_length = window_length();
      d.dest_memory   = MEM_W'($urandom_range(0, 1));
      d.dest_tiles    = pick_tiles();
      d.dest_offset   = window_offset();
      d.dest_length   = window_length();
    end
    return d;
  endfunction

  task automatic send_descriptor(input desc_t d);
    int unsigned gap;
    desc_bus.valid              <= 1'b1;
    desc_bus.queue_number       <= d.queue_number;
    desc_bus.profiling_dma      <= d.profiling_dma;
    desc_bus.source_is_constant <= d.source_is_constant;
    desc_bus.source_memory      <= d.source_memory;
    desc_bus.source_tiles       <= d.source_tiles;
    desc_bus.source_offset      <= d.source_offset;
    desc_bus.source_length      <= d.source_length;
    desc_bus.dest_memory        <= d.dest_memory;
    desc_bus.dest_tiles         <= d.dest_tiles;
    desc_bus.dest_offset        <= d.dest_offset;
    desc_bus.dest_length        <= d.dest_length;
    @(posedge clk);
    while (!desc_bus.ready) @(posedge clk);
    predict_ordering(d);
    gap = req_idling ? pick_gap() : 0;
    if (gap != 0) begin
      desc_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet until every expected decision beat has come back
  task automatic wait_for_decisions();
    desc_bus.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  task automatic test_queue_lifecycle();
    req_idling = 1'b1;
    rsp_idling = 1'b1;
    // zero-length destination, then a source spanning everything misses it
    send_descriptor(descriptor(0, 0, 0, 0, 0, 32'h0, 33'h0, 0, 0, 32'h0, 33'h0));
    send_descriptor(descriptor(0, 0, 0, 0, 0, 32'h0, 33'h1_0000_0000,
                               3, 6'h3F, 32'hFFFF_FFFF, 33'h1_0000_0000));
    send_descriptor(descriptor(0, 1, 1, 3, 6'h3F, 32'hFFFF_FFFF, 33'h1_0000_0000,
                               3, 6'h3F, 32'hFFFF_FFFF, 33'h1_0000_0000));
    send_descriptor(descriptor(0, 0, 0, 1, 1, 32'h100, 33'h40, 1, 1, 32'h100, 33'h40));
    send_descriptor(descriptor(15, 0, 1, 3, 6'h3F, 32'hFFFF_FFFF, 33'h1_0000_0000,
                               3, 6'h3F, 32'hFFFF_FFFF, 33'h1_0000_0000));
    // top byte of the address space, end beyond 32 bits
    send_descriptor(descriptor(15, 0, 0, 3, 6'h20, 32'hFFFF_FFFF, 33'h1,
                               2, 0, 32'h1000, 33'h10));
    send_descriptor(descriptor(15, 1, 1, 0, 0, 32'h0, 33'h0, 0, 0, 32'h0, 33'h0));
  endtask

  task automatic test_overlap_rules();
    send_descriptor(descriptor(5, 0, 0, 0, 0, 32'h0, 33'h0,
                               1, 6'b000011, 32'h200, 33'h100));
    // memory kind differs
    send_descriptor(descriptor(5, 0, 0, 2, 0, 32'h200, 33'h100,
                               1, 6'b110000, 32'h400, 33'h80));
    // tiles disjoint, then the entry is evicted
    send_descriptor(descriptor(5, 0, 0, 1, 6'b001100, 32'h200, 33'h10,
                               0, 0, 32'h800, 33'h20));
    send_descriptor(descriptor(5, 0, 0, 1, 6'b000001, 32'h200, 33'h100,
                               1, 0, 32'h1000, 33'h100));
    // entry without tile index, last byte overlaps
    send_descriptor(descriptor(5, 0, 0, 1, 6'b100000, 32'h10FF, 33'h1,
                               2, 6'b000100, 32'h300, 33'h100));
    // adjacent ranges on either side
    send_descriptor(descriptor(5, 0, 0, 2, 0, 32'h400, 33'h10,
                               2, 6'b000100, 32'h2000, 33'h40));
    send_descriptor(descriptor(5, 0, 0, 2, 6'b000100, 32'h2FF, 33'h1,
                               2, 6'b001000, 32'h2000, 33'h40));
    // hit on the older entry only
    send_descriptor(descriptor(5, 0, 0, 2, 6'b000110, 32'h203F, 33'h1,
                               0, 0, 32'h0, 33'h10));
    send_descriptor(descriptor(5, 0, 1, 0, 0, 32'h0, 33'h10, 0, 0, 32'h8, 33'h8));
    send_descriptor(descriptor(5, 0, 0, 0, 0, 32'h8, 33'h0, 1, 0, 32'h100, 33'h10));
    send_descriptor(descriptor(5, 0, 0, 0, 0, 32'hF, 33'h1, 0, 0, 32'h0, 33'h0));
    // interleaved queues keep separate histories
    send_descriptor(descriptor(14, 0, 0, 0, 0, 32'h0, 33'h0, 0, 0, 32'h0, 33'h20));
    send_descriptor(descriptor(5, 0, 0, 0, 0, 32'h0, 33'h20, 0, 0, 32'h40, 33'h20));
    send_descriptor(descriptor(14, 0, 0, 0, 6'h3F, 32'h1F, 33'h1, 0, 0, 32'h0, 33'h0));
    wait_for_decisions();
  endtask

  task automatic test_decision_backpressure();
    req_idling = 1'b0;
    hold_asked++;
    repeat (48) send_descriptor(random_descriptor());
    // sender waits for the whole backlog to drain
    wait_for_decisions();
  endtask

  task automatic test_random_traffic(input int unsigned total);
    int unsigned sent;
    sent = 0;
    while (sent < total) begin
      req_idling = ($urandom_range(0, 9) < 7);
      rsp_idling = ($urandom_range(0, 9) < 7);
      repeat (50) send_descriptor(random_descriptor());
      sent += 50;
      if ($urandom_range(0, 3) == 0) wait_for_decisions();
    end
  endtask

  // decision side ready, with random stalls and requested long holds
  initial begin : rsp_pacing
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left         = 0;
    holds_served       = 0;
    decision_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        decision_bus.ready <= 1'b0;
      end else if (holds_served != hold_asked) begin
        holds_served = hold_asked;
        decision_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left != 0) begin
        decision_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        decision_bus.ready <= 1'b1;
        if (rsp_idling) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    decision_t dec;
    if (!rst && decision_bus.valid && decision_bus.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("unexpected decision beat: out_of_order %0d, outcome %0d",
               decision_bus.out_of_order, decision_bus.outcome);
        fail_count++;
      end else begin
        dec = pending_decisions[0];
        pending_decisions.delete(0);
        if (decision_bus.out_of_order !== dec.out_of_order) begin
          $error("out_of_order: expected %0d, actual %0d",
                 dec.out_of_order, decision_bus.out_of_order);
          fail_count++;
        end
        if (decision_bus.outcome !== dec.outcome) begin
          $error("outcome: expected %0d, actual %0d", dec.outcome, decision_bus.outcome);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("dma_reorder_hazard_check_core test failed");
    $finish;
  end

  initial begin
    fail_count                  = 0;
    hold_asked                  = 0;
    req_idling                  = 1'b0;
    rsp_idling                  = 1'b0;
    rst                         = 1'b1;
    desc_bus.valid              = 1'b0;
    desc_bus.queue_number       = '0;
    desc_bus.profiling_dma      = 1'b0;
    desc_bus.source_is_constant = 1'b0;
    desc_bus.source_memory      = '0;
    desc_bus.source_tiles       = '0;
    desc_bus.source_offset      = '0;
    desc_bus.source_length      = '0;
    desc_bus.dest_memory        = '0;
    desc_bus.dest_tiles         = '0;
    desc_bus.dest_offset        = '0;
    desc_bus.dest_length        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_queue_lifecycle();
    test_overlap_rules();
    test_decision_backpressure();
    test_random_traffic(1200);

    wait_for_decisions();
    repeat (4 * (3 + HISTORY_DEPTH)) @(posedge clk);
    if (fail_count == 0 && pending_decisions.size() == 0) begin
      $display("dma_reorder_hazard_check_core test passed");
    end else begin
      $display("dma_reorder_hazard_check_core test failed");
    end
    $finish;
  end

endmodule
